// ===== hw/rtl/dgrs_pkg.sv =====
`timescale 1ns / 1ps

package dgrs_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_GEOMETRIC = 1024;
  localparam int MAX_ATTEMPTS = 1048576;
  localparam int NUM_SETS = 3;
  localparam int K_W = $clog2(MAX_GEOMETRIC + 1);
  localparam int ATT_W = $clog2(MAX_ATTEMPTS);
  localparam int RUN_W = 7;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int THR_W = 54;
  localparam int SAMPLE_W = 13;
  localparam int NUM_ENTRIES = NUM_SETS * 2 * TABLE_DEPTH;

  localparam logic [1:0] REG_SIGMA_SEL = 2'd0;
  localparam logic [1:0] REG_COSET = 2'd1;

  typedef logic [THR_W-1:0] thr_tab_t [NUM_ENTRIES];

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample;
    logic                status;
  } res_t;

  localparam logic [63:0] LN2_Q56 = 64'h00B17217F7D1CF79;

  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] frac_bits(input logic [63:0] rem_in,
                                             input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] f;
    rem = {1'b0, rem_in};
    f = '0;
    for (int b = 0; b < 56; b++) begin
      rem = rem << 1;
      f = f << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        f[0] = 1'b1;
      end
    end
    return f;
  endfunction

  function automatic logic [63:0] threshold(input int set, input int cs, input int k);
    logic [63:0] kb, m, mb, d, a, qi, q, x, n, step, term, sum, t, sh, j, p;
    logic [127:0] prod;
    kb = 64'd1;
    if (set == 0 && cs == 1) kb = 64'd0;
    d = (set == 0) ? 64'd1020100 : (set == 1) ? 64'd1633284 : 64'd1687401;
    m = 64'(2 * k + cs);
    mb = 2 * kb + 64'(cs);
    n = '0;
    if (m >= mb) begin
      j = 64'(k) - kb;
      a = (m * m - mb * mb) * 64'd125000;
      qi = udiv(a, d);
      if (qi * 64'd10000 >= 64'd370000 + 64'd6932 * j || qi >= 64'd255) return 64'd1;
      q = (qi << 56) + frac_bits(a - qi * d, d);
      step = j * LN2_Q56;
      x = (q >= step) ? q - step : 64'd0;
    end else begin
      step = (kb - 64'(k)) * LN2_Q56;
      a = (mb * mb - m * m) * 64'd125000;
      qi = udiv(a, d);
      if (qi >= 64'd255) return 64'd1;
      q = (qi << 56) + frac_bits(a - qi * d, d);
      x = (step >= q) ? step - q : 64'd0;
    end
    for (int r = 0; r < 512; r++) begin
      if (x >= LN2_Q56) begin
        x = x - LN2_Q56;
        n = n + 64'd1;
      end
    end
    x = x << 6;
    term = 64'd1 << 62;
    sum = 64'd1 << 62;
    for (int i = 1; i <= 24; i++) begin
      prod = {64'd0, term} * {64'd0, x};
      p = prod[125:62];
      term = udiv(p, 64'(i));
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    sh = 64'd9 + n;
    if (sh >= 64'd64) return 64'd1;
    t = sum >> sh;
    if ((sum & ((64'd1 << sh) - 64'd1)) != 64'd0) t = t + 64'd1;
    return (t == 64'd0) ? 64'd1 : t;
  endfunction

  function automatic thr_tab_t build_table();
    thr_tab_t tab;
    logic [63:0] v;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
          v = threshold(s, c, k);
          tab[(s * 2 + c) * TABLE_DEPTH + k] = v[THR_W-1:0];
        end
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TABLE = build_table();

endpackage

// ===== hw/rtl/discrete_gaussian_rejection_sampler_top.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Contents
// s_*       in   tdata: random_word[63:0]
// m_*       out  tdata: sample[12:0], zero fill; tuser: status
// cfg_*     in   index 0 sigma_sel, index 1 coset
// A request passes an input register, then combinational decision logic
// (trailing-ones count, threshold ROM lookup, compare) into the result register.
// One request is taken every cycle unless a stalled result backs up the input register.
// Only a deciding word or a failure gives a result; counting words give none.
// Reset is synchronous and clears the configuration, the attempt state and both registers.
// A stalled result holds the input register, and the input stalls once that is full too.

module discrete_gaussian_rejection_sampler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // random_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // sample[12:0], zeros
  output logic        m_tuser,   // status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  logic           in_valid;
  logic [63:0]    in_word;
  logic           advance;
  logic [1:0]     sigma_sel;
  logic           coset;
  dgrs_pkg::res_t res;

  assign advance = in_valid && (!res.valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma_sel <= 2'd0;
      coset <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dgrs_pkg::REG_SIGMA_SEL: sigma_sel <= (cfg_data == 2'd3) ? 2'd2 : cfg_data;
        dgrs_pkg::REG_COSET:     coset <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata;
    end
  end

  dgrs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ack       (m_tready),
    .word      (in_word),
    .sigma_sel (sigma_sel),
    .coset     (coset),
    .res       (res)
  );

  assign m_tvalid = res.valid;
  assign m_tdata = {3'b000, res.sample};
  assign m_tuser = res.status;

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[12:0] == 13'd0)
    else $error("failure result carries a nonzero sample");

  a_take_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted word not held in the input register");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or dropped");

endmodule

// ===== hw/rtl/dgrs_ones.sv =====
`timescale 1ns / 1ps

module dgrs_ones (
  input  logic [63:0]                 word,
  output logic [dgrs_pkg::RUN_W-1:0] run
);

  logic [64:0] plus_one;
  logic [64:0] lowest_zero;

  assign plus_one = {1'b0, word} + 65'd1;
  assign lowest_zero = {1'b1, ~word} & plus_one;

  always_comb begin
    run = '0;
    for (int i = 0; i <= 64; i++) begin
      if (lowest_zero[i]) begin
        run = run | dgrs_pkg::RUN_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/dgrs_core.sv =====
`timescale 1ns / 1ps

module dgrs_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 ack,
  input  logic [63:0]          word,
  input  logic [1:0]           sigma_sel,
  input  logic                 coset,
  output dgrs_pkg::res_t       res
);

  logic                          phase;
  logic                          phase_next;
  logic [dgrs_pkg::K_W-1:0]      gcount;
  logic [dgrs_pkg::K_W-1:0]      gcount_next;
  logic [dgrs_pkg::ATT_W-1:0]    attempts;
  logic [dgrs_pkg::ATT_W-1:0]    attempts_next;
  dgrs_pkg::res_t                res_next;
  logic [dgrs_pkg::RUN_W-1:0]    run;
  logic [dgrs_pkg::K_W:0]        gsum;
  logic [dgrs_pkg::K_W:0]        mag;
  logic [dgrs_pkg::THR_W-1:0]    thr;
  logic [52:0]                   uval;
  logic                          neg;
  logic                          accept;
  logic                          in_table;
  logic [1:0]                    set_sel;

  dgrs_ones u_ones (
    .word (word),
    .run  (run)
  );

  assign gsum = {1'b0, gcount} + (dgrs_pkg::K_W + 1)'(run);
  assign mag = {gcount, coset};
  assign neg = word[0];
  assign uval = word[63:11];
  assign in_table = (gcount < dgrs_pkg::K_W'(dgrs_pkg::TABLE_DEPTH));
  assign set_sel = (sigma_sel > 2'd2) ? 2'd2 : sigma_sel;
  assign thr = dgrs_pkg::THR_TABLE[{set_sel, coset, gcount[dgrs_pkg::IDX_W-1:0]}];
  assign accept = !((mag == '0) && neg) && in_table && ({1'b0, uval} < thr);

  always_comb begin
    phase_next = phase;
    gcount_next = gcount;
    attempts_next = attempts;
    res_next = res;
    if (ack) begin
      res_next.valid = 1'b0;
    end
    if (step) begin
      if (!phase) begin
        if (gsum > (dgrs_pkg::K_W + 1)'(dgrs_pkg::MAX_GEOMETRIC)) begin
          gcount_next = '0;
          attempts_next = '0;
          res_next.valid = 1'b1;
          res_next.sample = '0;
          res_next.status = 1'b1;
        end else begin
          gcount_next = gsum[dgrs_pkg::K_W-1:0];
          if (run != dgrs_pkg::RUN_W'(64)) begin
            phase_next = 1'b1;
          end
        end
      end else begin
        phase_next = 1'b0;
        gcount_next = '0;
        if (accept) begin
          attempts_next = '0;
          res_next.valid = 1'b1;
          res_next.sample = neg ? dgrs_pkg::SAMPLE_W'(-{1'b0, mag})
                                : dgrs_pkg::SAMPLE_W'(mag);
          res_next.status = 1'b0;
        end else if (attempts == dgrs_pkg::ATT_W'(dgrs_pkg::MAX_ATTEMPTS - 1)) begin
          attempts_next = '0;
          res_next.valid = 1'b1;
          res_next.sample = '0;
          res_next.status = 1'b1;
        end else begin
          attempts_next = attempts + dgrs_pkg::ATT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      gcount <= '0;
      attempts <= '0;
      res <= '0;
    end else begin
      phase <= phase_next;
      gcount <= gcount_next;
      attempts <= attempts_next;
      res <= res_next;
    end
  end

endmodule

// ===== tb/sv/discrete_gaussian_rejection_sampler_top_test.sv =====
`timescale 1ns / 1ps

module discrete_gaussian_rejection_sampler_top_test;

  typedef struct packed {
    logic [dgrs_pkg::SAMPLE_W-1:0] sample;
    logic                          status;
  } sample_result_t;

  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;

  discrete_gaussian_rejection_sampler_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [63:0]    random_words [$];
  sample_result_t expected_samples [$];
  logic [63:0]    accept_limit_rom [3][2][dgrs_pkg::TABLE_DEPTH];

  // Predicted sampler state.
  logic  counting_done;
  int    trailing_total;
  int    rejected_attempts;
  int    active_set;
  int    active_coset;

  // Stimulus-side view of the attempt phase and of the configuration.
  logic  plan_counting_done;
  int    plan_total;
  int    plan_set;
  int    plan_coset;

  logic  word_taken;
  logic  sample_taken;
  logic  back_to_back;
  int    burst_left;
  int    gap_left;
  int    hold_left;
  int    receiver_cycles;
  int    stall_mode;
  int    quiet_cycles;
  int    mismatches;
  int    failures;

  always #5 clk = ~clk;

  function automatic logic [63:0] accept_limit(input int ps, input int cs, input int k);
    logic [63:0]  kb, d, m, mb, a, qi, q, st, x, n, term, sum, t, j;
    logic [127:0] wide;
    kb = (ps == 0 && cs == 1) ? 64'd0 : 64'd1;
    d = (ps == 0) ? 64'd1020100 : (ps == 1) ? 64'd1633284 : 64'd1687401;
    m = 64'(2 * k + cs);
    mb = 2 * kb + 64'(cs);
    if (m >= mb) begin
      j = 64'(k) - kb;
      a = (m * m - mb * mb) * 64'd125000;
      qi = a / d;
      if (qi * 64'd10000 >= 64'd370000 + 64'd6932 * j || qi >= 64'd255) return 64'd1;
      wide = {64'd0, a % d} << 56;
      q = (qi << 56) + 64'(wide / {64'd0, d});
      st = j * dgrs_pkg::LN2_Q56;
      x = (q >= st) ? q - st : 64'd0;
    end else begin
      st = (kb - 64'(k)) * dgrs_pkg::LN2_Q56;
      a = (mb * mb - m * m) * 64'd125000;
      qi = a / d;
      if (qi >= 64'd255) return 64'd1;
      wide = {64'd0, a % d} << 56;
      q = (qi << 56) + 64'(wide / {64'd0, d});
      x = (st >= q) ? st - q : 64'd0;
    end
    n = x / dgrs_pkg::LN2_Q56;
    x = (x % dgrs_pkg::LN2_Q56) << 6;
    term = 64'd1 << 62;
    sum = term;
    for (int i = 1; i <= 24; i++) begin
      wide = {64'd0, term} * {64'd0, x};
      term = 64'(wide >> 62) / 64'(i);
      if (i % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    if (n >= 64'd55) return 64'd1;
    t = sum >> (n + 64'd9);
    if ((sum & ((64'd1 << (n + 64'd9)) - 64'd1)) != 64'd0) t = t + 64'd1;
    return (t == 64'd0) ? 64'd1 : t;
  endfunction

  function automatic int trailing_ones(input logic [63:0] w);
    int run;
    run = 0;
    while (run < 64 && w[run]) run++;
    return run;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic clear_attempt_state();
    counting_done = 1'b0;
    trailing_total = 0;
    rejected_attempts = 0;
  endtask

  task automatic report_source_failure();
    clear_attempt_state();
    expected_samples.push_back('{sample: '0, status: 1'b1});
  endtask

  task automatic predict_sample(input logic [63:0] w);
    int          run;
    int          magnitude;
    logic        negative;
    logic [63:0] uniform;
    logic        accepted;
    logic [dgrs_pkg::SAMPLE_W-1:0] signed_value;
    if (!counting_done) begin
      run = trailing_ones(w);
      if (trailing_total + run > dgrs_pkg::MAX_GEOMETRIC) begin
        report_source_failure();
      end else begin
        trailing_total += run;
        if (run != 64) counting_done = 1'b1;
      end
    end else begin
      magnitude = 2 * trailing_total + active_coset;
      negative = w[0];
      uniform = w >> 11;
      accepted = 1'b0;
      if (!(magnitude == 0 && negative) && trailing_total < dgrs_pkg::TABLE_DEPTH)
        accepted = uniform < accept_limit_rom[active_set][active_coset][trailing_total];
      counting_done = 1'b0;
      trailing_total = 0;
      if (accepted) begin
        rejected_attempts = 0;
        signed_value = negative ? dgrs_pkg::SAMPLE_W'(-magnitude)
                                : dgrs_pkg::SAMPLE_W'(magnitude);
        expected_samples.push_back('{sample: signed_value, status: 1'b0});
      end else begin
        rejected_attempts++;
        if (rejected_attempts >= dgrs_pkg::MAX_ATTEMPTS) report_source_failure();
      end
    end
  endtask

  task automatic check_sample();
    sample_result_t want;
    if (expected_samples.size() == 0) begin
      failures++;
      if (mismatches < 10)
        $display("ERROR: result with none pending, sample %h status %b", m_tdata, m_tuser);
      mismatches++;
    end else begin
      want = expected_samples.pop_front();
      if (m_tdata !== {3'b000, want.sample} || m_tuser !== want.status) begin
        failures++;
        if (mismatches < 10)
          $display("ERROR: expected sample %h status %b, got sample %h status %b",
                   want.sample, want.status, m_tdata, m_tuser);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    word_taken = !rst && s_tvalid && s_tready;
    sample_taken = !rst && m_tvalid && m_tready;
    if (rst) begin
      active_set = 0;
      active_coset = 0;
      clear_attempt_state();
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == dgrs_pkg::REG_SIGMA_SEL)
          active_set = (cfg_data > 2'd2) ? 2 : int'(cfg_data);
        else if (cfg_index == dgrs_pkg::REG_COSET)
          active_coset = int'(cfg_data[0]);
      end
      if (word_taken) predict_sample(s_tdata);
      if (sample_taken) check_sample();
      if (word_taken || sample_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (word_taken) void'(random_words.pop_front());
      if (s_tvalid && !word_taken) begin
      end else if (!back_to_back && gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (random_words.size() > 0) begin
        s_tdata <= random_words[0];
        s_tvalid <= 1'b1;
        if (!back_to_back) begin
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    receiver_cycles++;
    if (back_to_back) begin
      m_tready <= 1'b1;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      if (receiver_cycles == 600) hold_left = 400;
      if (receiver_cycles % 256 == 0) stall_mode = $urandom % 3;
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom % 4 != 0);
        default: m_tready <= ($urandom % 4 == 0);
      endcase
    end
  end

  task automatic queue_word(input logic [63:0] w);
    int run;
    random_words.push_back(w);
    if (!plan_counting_done) begin
      run = trailing_ones(w);
      if (plan_total + run > dgrs_pkg::MAX_GEOMETRIC) begin
        plan_total = 0;
      end else begin
        plan_total += run;
        if (run != 64) plan_counting_done = 1'b1;
      end
    end else begin
      plan_counting_done = 1'b0;
      plan_total = 0;
    end
  endtask

  // uniform_pick: 0 just below the limit, 1 at the limit, 2 any, 3 small, 4 zero, 5 maximum.
  task automatic queue_attempt(input int k, input logic sgn, input int uniform_pick);
    int          left;
    logic [63:0] limit;
    logic [63:0] uniform;
    if (plan_counting_done) queue_word(random_word());
    left = k;
    while (left >= 64) begin
      queue_word('1);
      left -= 64;
    end
    queue_word((random_word() << (left + 1)) | ((64'd1 << left) - 64'd1));
    limit = (k < dgrs_pkg::TABLE_DEPTH) ? accept_limit_rom[plan_set][plan_coset][k]
                                        : random_word();
    case (uniform_pick)
      0: uniform = limit - 64'd1;
      1: uniform = limit;
      2: uniform = random_word();
      3: uniform = random_word() >> $urandom_range(1, 63);
      4: uniform = '0;
      default: uniform = '1;
    endcase
    queue_word({uniform[52:0], 10'($urandom), sgn});
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sampler(input int ps, input int cs);
    write_register(dgrs_pkg::REG_SIGMA_SEL, 2'(ps));
    write_register(dgrs_pkg::REG_COSET, 2'(cs));
    plan_set = (ps > 2) ? 2 : ps;
    plan_coset = cs;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (random_words.size() != 0 || s_tvalid || expected_samples.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_random_mix(input int count);
    int goal;
    int pick;
    int k;
    goal = random_words.size() + count;
    while (random_words.size() < goal) begin
      pick = $urandom % 20;
      if (pick < 2) begin
        queue_word(random_word());
      end else begin
        pick = $urandom % 20;
        if (pick < 14) k = trailing_ones(random_word()) % 6;
        else if (pick < 18) k = $urandom_range(0, 70);
        else if (pick < 19) k = $urandom_range(64, 300);
        else k = $urandom_range(900, 1030);
        queue_attempt(k, 1'($urandom), $urandom % 6);
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    back_to_back = 1'b0;
    burst_left = 8;
    gap_left = 0;
    hold_left = 0;
    receiver_cycles = 0;
    stall_mode = 0;
    mismatches = 0;
    failures = 0;
    plan_counting_done = 1'b0;
    plan_total = 0;
    plan_set = 0;
    plan_coset = 0;
    for (int s = 0; s < 3; s++)
      for (int c = 0; c < 2; c++)
        for (int k = 0; k < dgrs_pkg::TABLE_DEPTH; k++)
          accept_limit_rom[s][c][k] = accept_limit(s, c, k);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_sampler(0, 0);
    queue_attempt(0, 1'b1, 4);
    queue_attempt(0, 1'b0, 4);
    queue_attempt(0, 1'b0, 0);
    queue_attempt(0, 1'b0, 1);
    queue_attempt(1, 1'b1, 4);
    queue_attempt(63, 1'b0, 4);
    queue_attempt(64, 1'b0, 4);
    queue_attempt(0, 1'b1, 5);
    for (int i = 0; i < 17; i++) queue_word('1);
    queue_random_mix(200);
    wait_drained();

    set_sampler(0, 1);
    queue_attempt(0, 1'b1, 4);
    queue_attempt(0, 1'b0, 0);
    queue_random_mix(220);
    wait_drained();

    set_sampler(1, 0);
    write_register(2'd2, 2'b11);
    queue_random_mix(220);
    wait_drained();

    set_sampler(1, 1);
    write_register(2'd3, 2'b01);
    queue_random_mix(220);
    wait_drained();

    set_sampler(3, 0);
    queue_random_mix(220);
    wait_drained();

    set_sampler(2, 1);
    queue_random_mix(220);
    wait_drained();

    set_sampler(0, 0);
    back_to_back = 1'b1;
    for (int i = 0; i < 17; i++) queue_word('1);
    queue_random_mix(20);
    wait_drained();

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/dgrs_pkg.sv
hw/rtl/dgrs_ones.sv
hw/rtl/dgrs_core.sv
hw/rtl/discrete_gaussian_rejection_sampler_top.sv
tb/sv/discrete_gaussian_rejection_sampler_top_test.sv
